// File: rtl/core/ihrl_pkg.sv
package ihrl_pkg;

   localparam int ImageBytes = 65536;
   localparam int AddrBits = $clog2(ImageBytes);
   localparam int MaxRecordBytes = 261;
   localparam int PosBits = 9;
   localparam int QueueDepth = 2;

   localparam logic [7:0] RecData = 8'h00;
   localparam logic [7:0] RecEof = 8'h01;
   localparam logic [7:0] RecExtLin = 8'h04;
   localparam logic [7:0] ChColon = 8'h3A;
   localparam logic [7:0] ChLineFeed = 8'h0A;

   typedef enum logic [2:0] {
      ST_NONE = 3'd0,
      ST_DATA = 3'd1,
      ST_EOF = 3'd2,
      ST_RESET = 3'd3,
      ST_IGNORED = 3'd4,
      ST_REJECTED = 3'd5
   } status_type;

   typedef struct packed {
      logic kind;
      logic [7:0] char_code;
      logic [15:0] read_address;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [15:0] image_length;
      logic [7:0] record_type;
      logic [7:0] read_byte;
   } rsp_type;

   // one classified request handed from front to back
   typedef struct packed {
      logic is_read;
      logic [AddrBits-1:0] read_addr;
      logic write_en;
      logic [AddrBits-1:0] write_addr;
      logic [7:0] write_data;
      logic [2:0] status;
      logic [15:0] image_length;
      logic [7:0] record_type;
   } op_type;

   function automatic logic [4:0] hex_value(input logic [7:0] ch);
      logic [4:0] r;
      r = 5'h10;
      if (ch >= 8'h30 && ch <= 8'h39) r = {1'b0, 4'(ch - 8'h30)};
      else if (ch >= 8'h61 && ch <= 8'h66) r = {1'b0, 4'(ch - 8'h57)};
      else if (ch >= 8'h41 && ch <= 8'h46) r = {1'b0, 4'(ch - 8'h37)};
      return r;
   endfunction

endpackage

// File: rtl/core/ihrl_ram.sv
module ihrl_ram #(
   parameter int Width = 8,
   parameter int Depth = 1024
) (
   input  logic clock,
   input  logic write_en,
   input  logic [$clog2(Depth)-1:0] write_addr,
   input  logic [Width-1:0] write_data,
   input  logic read_en,
   input  logic [$clog2(Depth)-1:0] read_addr,
   output logic [Width-1:0] read_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (write_en) mem[write_addr] <= write_data;
      if (read_en) read_data <= mem[read_addr];
   end
endmodule

// File: rtl/core/ihrl_front.sv
module ihrl_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  ihrl_pkg::req_type req_data,
   output logic op_valid,
   input  logic op_stall,
   output ihrl_pkg::op_type op_data
);
   import ihrl_pkg::*;

   logic in_record_ff, in_record_in;
   logic stopped_ff, stopped_in;
   logic low_due_ff, low_due_in;
   logic [3:0] high_ff, high_in;
   logic [PosBits-1:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] plen_ff, plen_in;
   logic [7:0] type_ff, type_in;
   logic [15:0] clen_ff, clen_in;
   logic take;
   logic [4:0] d;
   logic [7:0] b;
   logic [PosBits-1:0] idx;
   op_type op;

   assign req_stall = op_stall;
   assign take = req_valid && !req_stall;
   assign op_valid = req_valid;
   assign op_data = op;
   assign d = hex_value(req_data.char_code);
   assign b = {high_ff, d[3:0]};
   assign idx = pos_ff - PosBits'(4);

   always_comb begin
      in_record_in = in_record_ff;
      stopped_in = stopped_ff;
      low_due_in = low_due_ff;
      high_in = high_ff;
      pos_in = pos_ff;
      sum_in = sum_ff;
      plen_in = plen_ff;
      type_in = type_ff;
      clen_in = clen_ff;
      op = '0;
      op.read_addr = req_data.read_address[AddrBits-1:0];
      op.write_data = b;
      op.write_addr = AddrBits'(clen_ff + 16'(idx));
      if (req_data.kind) begin
         op.is_read = 1'b1;
      end else if (req_data.char_code == ChLineFeed) begin
         if (in_record_ff && pos_ff != '0 && sum_ff == 8'h00) begin
            op.record_type = type_ff;
            unique case (type_ff)
               RecData: begin
                  clen_in = 16'(AddrBits'(clen_ff + 16'(plen_ff)));
                  op.status = ST_DATA;
               end
               RecEof: op.status = ST_EOF;
               RecExtLin: begin
                  clen_in = '0;
                  op.status = ST_RESET;
               end
               default: op.status = ST_IGNORED;
            endcase
         end else begin
            op.status = ST_REJECTED;
         end
         in_record_in = 1'b0;
         stopped_in = 1'b0;
         low_due_in = 1'b0;
         high_in = '0;
         pos_in = '0;
         sum_in = '0;
         plen_in = '0;
         type_in = '0;
      end else if (!in_record_ff) begin
         if (req_data.char_code == ChColon) in_record_in = 1'b1;
      end else if (!stopped_ff) begin
         if (d[4]) begin
            stopped_in = 1'b1;
            low_due_in = 1'b0;
         end else if (!low_due_ff) begin
            high_in = d[3:0];
            low_due_in = 1'b1;
         end else begin
            low_due_in = 1'b0;
            if (pos_ff >= PosBits'(MaxRecordBytes)) begin
               stopped_in = 1'b1;
            end else begin
               sum_in = sum_ff + b;
               if (pos_ff == PosBits'(0)) plen_in = b;
               else if (pos_ff == PosBits'(3)) type_in = b;
               else if (pos_ff >= PosBits'(4) && type_ff == RecData
                        && idx < PosBits'(plen_ff))
                  op.write_en = 1'b1;
               pos_in = pos_ff + PosBits'(1);
            end
         end
      end
      op.image_length = clen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_record_ff <= 1'b0;
         stopped_ff <= 1'b0;
         low_due_ff <= 1'b0;
         high_ff <= '0;
         pos_ff <= '0;
         sum_ff <= '0;
         plen_ff <= '0;
         type_ff <= '0;
         clen_ff <= '0;
      end else if (take) begin
         in_record_ff <= in_record_in;
         stopped_ff <= stopped_in;
         low_due_ff <= low_due_in;
         high_ff <= high_in;
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         plen_ff <= plen_in;
         type_ff <= type_in;
         clen_ff <= clen_in;
      end
   end

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosBits'(MaxRecordBytes)) else $error("byte position overran");
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !in_record_ff |-> (pos_ff == '0 && sum_ff == '0)) else $error("stale record");
   a_write_in_record: assert property (@(posedge clock) disable iff (reset)
      (op_valid && op.write_en) |-> (in_record_ff && type_ff == RecData))
      else $error("write outside data record");
endmodule

// File: rtl/core/ihrl_back.sv
module ihrl_back (
   input  logic clock,
   input  logic reset,
   input  logic op_valid,
   output logic op_stall,
   input  ihrl_pkg::op_type op_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output ihrl_pkg::rsp_type rsp_data
);
   import ihrl_pkg::*;

   // stage 1: RAM read in flight; then a two-entry result queue
   logic s1_valid_ff;
   op_type s1_ff;
   logic [7:0] rd;
   rsp_type q_ff [QueueDepth];
   logic [1:0] count_ff, count_in;
   logic rd_ptr_ff, wr_ptr_ff;
   logic op_take, q_push, q_pop;
   rsp_type push_item;

   // admit a new op only if a queue slot is sure to be free for it
   assign op_stall = ((2'(count_ff) + 2'(s1_valid_ff)) >= 2'(QueueDepth)) && !q_pop;
   assign op_take = op_valid && !op_stall;
   assign q_push = s1_valid_ff;
   assign q_pop = rsp_valid && !rsp_stall;
   assign rsp_valid = count_ff != '0;
   assign rsp_data = q_ff[rd_ptr_ff];

   ihrl_ram #(.Width(8), .Depth(ImageBytes)) u_image (
      .clock(clock),
      .write_en(op_take && op_data.write_en),
      .write_addr(op_data.write_addr),
      .write_data(op_data.write_data),
      .read_en(op_take && op_data.is_read),
      .read_addr(op_data.read_addr),
      .read_data(rd)
   );

   always_comb begin
      push_item.status = s1_ff.status;
      push_item.image_length = s1_ff.image_length;
      push_item.record_type = s1_ff.record_type;
      push_item.read_byte = s1_ff.is_read ? rd : 8'h00;
      count_in = count_ff + 2'(q_push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         count_ff <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         s1_valid_ff <= op_take;
         count_ff <= count_in;
         if (q_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (op_take) s1_ff <= op_data;
      if (q_push) q_ff[wr_ptr_ff] <= push_item;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (count_ff < 2'(QueueDepth) || q_pop)) else $error("queue overflow");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QueueDepth)) else $error("queue count");
   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      op_take |-> !(op_data.is_read && op_data.write_en)) else $error("read and write");
endmodule

// File: rtl/core/intel_hex_record_loader.sv
// Intel HEX loader: one character or one image read per request, one response
// per request. Requests are accepted back to back, one per clock, unless the read
// stage and output queue are full and the receiver stalls; each response passes
// through the registered read of the 64 KiB image RAM and then a two-entry output
// queue. Reads of bytes never written return undefined data.
module intel_hex_record_loader (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  ihrl_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output ihrl_pkg::rsp_type rsp_data
);
   import ihrl_pkg::*;

   logic op_valid, op_stall;
   op_type op_data;

   ihrl_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .op_valid(op_valid), .op_stall(op_stall), .op_data(op_data)
   );

   ihrl_back u_back (
      .clock(clock), .reset(reset),
      .op_valid(op_valid), .op_stall(op_stall), .op_data(op_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );
endmodule

// File: bench/ihrl_checker.sv
module ihrl_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  ihrl_pkg::req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  ihrl_pkg::rsp_type rsp_data,
   output int fail_count,
   output int pending_count,
   output int accept_count
);
   import ihrl_pkg::*;

   logic in_rec, stopped, low_due;
   logic [3:0] hi_hold;
   logic [8:0] pos;
   logic [7:0] sum, pay_len, rec_type;
   logic [15:0] committed;
   logic [7:0] image [0:65535];
   rsp_type expected_rsps[$];

   function automatic logic [4:0] nibble_of(input logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return {1'b0, 4'(ch - "0")};
      if (ch >= "a" && ch <= "f") return {1'b0, 4'(ch - "a" + 10)};
      if (ch >= "A" && ch <= "F") return {1'b0, 4'(ch - "A" + 10)};
      return 5'h10;
   endfunction

   task automatic clear_rec();
      in_rec = 0; stopped = 0; low_due = 0; hi_hold = 0;
      pos = 0; sum = 0; pay_len = 0; rec_type = 0;
   endtask

   task automatic take_byte(input logic [7:0] b);
      logic [15:0] idx;
      if (pos >= MaxRecordBytes) begin
         stopped = 1;
         return;
      end
      sum = sum + b;
      if (pos == 0) pay_len = b;
      else if (pos == 3) rec_type = b;
      else if (pos >= 4) begin
         idx = 16'(pos - 4);
         if (rec_type == RecData && idx < pay_len) image[committed + idx] = b;
      end
      pos = pos + 1;
   endtask

   task automatic predict_loader(input req_type r);
      rsp_type e;
      logic [4:0] d;
      e = '0;
      if (r.kind) e.read_byte = image[r.read_address];
      else if (r.char_code == ChLineFeed) begin
         if (in_rec && pos > 0 && sum == 0) begin
            e.record_type = rec_type;
            if (rec_type == RecData) begin
               committed = committed + pay_len;
               e.status = ST_DATA;
            end else if (rec_type == RecEof) e.status = ST_EOF;
            else if (rec_type == RecExtLin) begin
               committed = 0;
               e.status = ST_RESET;
            end else e.status = ST_IGNORED;
         end else e.status = ST_REJECTED;
         clear_rec();
      end else if (!in_rec) begin
         if (r.char_code == ChColon) begin
            clear_rec();
            in_rec = 1;
         end
      end else if (!stopped) begin
         d = nibble_of(r.char_code);
         if (d[4]) begin
            stopped = 1;
            low_due = 0;
         end else if (!low_due) begin
            hi_hold = d[3:0];
            low_due = 1;
         end else begin
            low_due = 0;
            take_byte({hi_hold, d[3:0]});
         end
      end
      e.image_length = committed;
      expected_rsps.push_back(e);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      int n_acc;
      n_acc = 0;
      if (reset) begin
         clear_rec();
         committed = 0;
         expected_rsps.delete();
         fail_count <= 0;
         accept_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_acc++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %h", $realtime, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_data !== e) begin
                  $display("%0t: mismatch expected st=%0d len=%h typ=%h rd=%h",
                           $realtime, e.status, e.image_length, e.record_type,
                           e.read_byte);
                  $display("%0t:          actual   st=%0d len=%h typ=%h rd=%h",
                           $realtime, rsp_data.status, rsp_data.image_length,
                           rsp_data.record_type, rsp_data.read_byte);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            n_acc++;
            predict_loader(req_data);
         end
         accept_count <= accept_count + n_acc;
      end
      pending_count = expected_rsps.size();
   end
endmodule

// File: bench/tb_intel_hex_record_loader.sv
module tb_intel_hex_record_loader;
   import ihrl_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_type rsp_data;
   int fail_count, pending_count, accept_count;
   int send_idle_pct = 0, stall_pct = 0;
   int hold_requests = 0, hold_seen = 0, hold_left = 0;
   int sent = 0, records = 0;
   logic [15:0] written_top = 0;   // image bytes known to be written below this
   logic timed_out = 0;

   always #2 clock = ~clock;

   intel_hex_record_loader dut (.*);
   ihrl_checker chk (.*);

   // a new hold request starts a long stretch of receiver stall
   always @(negedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen <= hold_requests;
         hold_left <= 59;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_request(input logic kind, input logic [7:0] ch,
                               input logic [15:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= '{kind: kind, char_code: ch, read_address: addr};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_char(input logic [7:0] ch);
      send_request(0, ch, 16'($urandom));
   endtask

   task automatic send_hex_byte(input logic [7:0] b, input bit upper);
      string digits;
      digits = upper ? "0123456789ABCDEF" : "0123456789abcdef";
      send_char(digits[b[7:4]]);
      send_char(digits[b[3:0]]);
   endtask

   // well-formed record; corrupt bends the sum and may insert a stray character
   task automatic send_record(input logic [7:0] typ, input int len, input bit corrupt);
      logic [7:0] s, b;
      bit upper;
      upper = $urandom_range(1);
      s = 8'(len) + typ + 8'($urandom) ;
      send_char(ChColon);
      send_hex_byte(8'(len), upper);
      b = s - 8'(len) - typ;
      send_hex_byte(b, upper);
      send_hex_byte(8'h00, upper);
      send_hex_byte(typ, upper);
      s = 8'(len) + b + typ;
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom);
         s += b;
         send_hex_byte(b, upper);
      end
      if (corrupt && $urandom_range(1)) send_char(8'($urandom_range(255)));
      send_hex_byte(corrupt ? -s + 8'd1 : -s, upper);
      if ($urandom_range(3) == 0) send_char(8'h0D);
      send_char(ChLineFeed);
      records++;
      if (!corrupt && typ == RecData && 32'(written_top) + len < 65536)
         written_top += 16'(len);
   endtask

   task automatic send_read();
      if (written_top != 0) send_request(1, 8'($urandom), 16'($urandom_range(written_top - 1)));
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_phase(input int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 55) send_record(RecData, $urandom_range(12), 0);
         else if (pick < 70) send_read();
         else if (pick < 78) send_record(RecData, $urandom_range(8), 1);
         else if (pick < 82) send_record(8'($urandom_range(2, 255)), $urandom_range(3), 0);
         else if (pick < 85) send_record(RecEof, 0, 0);
         else send_char(8'($urandom));
      end
   endtask

   initial begin : watchdog
      int idle;
      int last;
      idle = 0; last = 0;
      forever begin
         @(posedge clock);
         if (accept_count != last) idle = 0; else idle++;
         last = accept_count;
         if (idle > 5000) begin
            timed_out = 1;
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed
      send_char(ChLineFeed);                 // line feed outside record
      send_char(8'h00);
      send_char(8'hFF);
      send_record(RecData, 4, 0);
      send_read();
      send_record(RecData, 0, 0);
      send_record(RecEof, 0, 0);
      send_record(8'h02, 1, 0);
      send_record(RecData, 3, 1);
      send_char(ChColon); send_char("1"); send_char(ChColon); send_char(ChLineFeed);
      send_char(ChColon); send_char(ChLineFeed);
      send_char(ChColon); send_char("g"); send_char(ChLineFeed);
      send_record(RecData, 24, 0);           // longer payload
      send_read();
      drain();
      // pre-written region only readable below written_top; length reset keeps it valid
      random_phase(3);
      send_idle_pct = 51; random_phase(3);
      send_idle_pct = 0; stall_pct = 51; random_phase(3);
      send_idle_pct = 10; stall_pct = 10; random_phase(3);
      drain();
      hold_requests++;
      send_idle_pct = 0; stall_pct = 0;
      random_phase(2);
      drain();
      send_record(RecExtLin, 0, 0);
      send_record(RecData, 2, 0);
      random_phase(2);
      drain();
      repeat (20) @(negedge clock);
      $display("Sent %0d requests in %0d records, with both sides idling and a long hold-off.",
               sent, records);
      if (fail_count == 0 && !timed_out) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
